// ----- hw/rtl/bdpc_pkg.sv -----
// Shared types, constants and register codes of the button debounce and press classifier.
`timescale 1ns / 1ps

package bdpc_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int BTN_IDX_W   = 1;
	localparam int TIME_W      = 32;
	localparam int DEB_W       = 10;
	localparam int LIM_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [NUM_BUTTONS-1:0] ENABLE_RST   = '0;
	localparam logic [DEB_W-1:0]       DEBOUNCE_RST = DEB_W'(100);
	localparam logic [LIM_W-1:0]       SHORT_RST    = LIM_W'(2000);
	localparam logic [LIM_W-1:0]       MEDIUM_RST   = LIM_W'(5000);
	localparam logic [LIM_W-1:0]       LONG_RST     = LIM_W'(10000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_MASK = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_SHORT_LIM   = 3'd2,
		REG_MEDIUM_LIM  = 3'd3,
		REG_LONG_LIM    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PT_SHORT     = 2'd0,
		PT_MEDIUM    = 2'd1,
		PT_LONG      = 2'd2,
		PT_VERY_LONG = 2'd3
	} press_type_t;

	typedef struct packed {
		logic              evt;
		logic              pressed;
		logic [TIME_W-1:0] dur;
	} lane_evt_t;

	typedef struct packed {
		logic [LIM_W-1:0] short_lim;
		logic [LIM_W-1:0] medium_lim;
		logic [LIM_W-1:0] long_lim;
	} limits_t;

endpackage

// ----- hw/rtl/bdpc_if.sv -----
// Handshake channel interfaces for ticks, events and configuration writes.
`timescale 1ns / 1ps

interface bdpc_tick_if;
	logic                                valid;
	logic                                ready;
	logic [bdpc_pkg::NUM_BUTTONS-1:0]    raw_levels;
	modport source (output valid, output raw_levels, input ready);
	modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bdpc_evt_if;
	logic                                valid;
	logic                                ready;
	logic [bdpc_pkg::BTN_IDX_W-1:0]      button_index;
	logic                                pressed;
	logic [1:0]                          press_type;
	logic [bdpc_pkg::TIME_W-1:0]         event_time_ms;
	logic                                last_event;
	modport source (output valid, output button_index, output pressed, output press_type,
		output event_time_ms, output last_event, input ready);
	modport sink   (input valid, input button_index, input pressed, input press_type,
		input event_time_ms, input last_event, output ready);
endinterface

interface bdpc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [bdpc_pkg::CFG_IDX_W-1:0]      index;
	logic [bdpc_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bdpc_lane.sv -----
// Per-button debounce lane: window counter, debounced state and press timestamp.
`timescale 1ns / 1ps

module bdpc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          enable,
	input  logic                          level,
	input  logic                          prev,
	input  logic [bdpc_pkg::DEB_W-1:0]    deb_ticks,
	input  logic [bdpc_pkg::TIME_W-1:0]   time_ms,
	output bdpc_pkg::lane_evt_t           evt_s1
);
	import bdpc_pkg::*;

	logic              deb_q;
	logic              snap_q;
	logic              active_q;
	logic [DEB_W-1:0]  count_q;
	logic [TIME_W-1:0] press_time_q;

	logic              expire;
	logic              now_p;
	logic              fire;
	logic              deb_n;
	logic              active_mid;
	logic              open_win;
	logic [DEB_W-1:0]  cnt_dec;
	logic [DEB_W-1:0]  win_len;
	logic [TIME_W-1:0] dur_n;

	always_comb begin
		cnt_dec    = count_q - DEB_W'(1);
		expire     = active_q && (cnt_dec == '0);
		now_p      = ~level;
		fire       = expire && (now_p != snap_q);
		deb_n      = expire ? now_p : deb_q;
		active_mid = active_q && !expire;
		open_win   = (level != prev) && !active_mid;
		win_len    = (deb_ticks == '0) ? DEB_W'(1) : deb_ticks;
		dur_n      = now_p ? '0 : (time_ms - press_time_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q        <= 1'b0;
			snap_q       <= 1'b0;
			active_q     <= 1'b0;
			count_q      <= '0;
			press_time_q <= '0;
			evt_s1       <= '0;
		end else if (accept) begin
			evt_s1.evt     <= enable && fire;
			evt_s1.pressed <= now_p;
			evt_s1.dur     <= dur_n;
			if (enable) begin
				deb_q <= deb_n;
				if (active_q) begin
					count_q <= cnt_dec;
				end
				active_q <= active_mid;
				if (open_win) begin
					snap_q   <= deb_n;
					active_q <= 1'b1;
					count_q  <= win_len;
				end
				if (fire && now_p) begin
					press_time_q <= time_ms;
				end
			end
		end
	end

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (count_q != '0))
		else $error("open debounce window with zero count");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(accept && enable) |-> ($stable(count_q) && $stable(press_time_q)))
		else $error("lane state moved without an enabled tick");

	a_evt_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !enable) |=> !evt_s1.evt)
		else $error("disabled lane raised an event");

endmodule

// ----- hw/rtl/bdpc_merge.sv -----
// Merging stage: serializes lane events of one tick in slot order and classifies durations.
`timescale 1ns / 1ps

module bdpc_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [bdpc_pkg::TIME_W-1:0]   time_ms,
	input  bdpc_pkg::lane_evt_t           evts [bdpc_pkg::NUM_BUTTONS],
	input  bdpc_pkg::limits_t             limits,
	output logic                          in_ready,
	bdpc_evt_if.source                    evt
);
	import bdpc_pkg::*;

	logic                   s1_valid_q;
	logic [NUM_BUTTONS-1:0] served_q;
	logic [TIME_W-1:0]      time_s1;

	logic                   out_valid_q;
	logic [BTN_IDX_W-1:0]   idx_q;
	logic                   pressed_q;
	press_type_t            type_q;
	logic [TIME_W-1:0]      etime_q;
	logic                   last_q;

	logic [NUM_BUTTONS-1:0] mask;
	logic [NUM_BUTTONS-1:0] pend;
	logic [NUM_BUTTONS-1:0] onehot;
	logic [NUM_BUTTONS-1:0] remaining;
	logic [BTN_IDX_W-1:0]   sel;
	logic                   found;
	logic                   take;
	logic                   load;
	logic                   done;
	logic [TIME_W-1:0]      sel_dur;
	press_type_t            sel_type;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			mask[i] = evts[i].evt;
		end
		pend  = s1_valid_q ? (mask & ~served_q) : '0;
		sel   = '0;
		found = 1'b0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (pend[i]) begin
				sel   = BTN_IDX_W'(i);
				found = 1'b1;
			end
		end
		onehot      = '0;
		onehot[sel] = found;
		remaining   = pend & ~onehot;
		take        = !out_valid_q || evt.ready;
		load        = found && take;
		done        = s1_valid_q && (!found || (take && (remaining == '0)));
		in_ready    = !s1_valid_q || done;
		sel_dur     = evts[sel].dur;
		priority if (sel_dur < TIME_W'(limits.short_lim)) begin
			sel_type = PT_SHORT;
		end else if (sel_dur < TIME_W'(limits.medium_lim)) begin
			sel_type = PT_MEDIUM;
		end else if (sel_dur < TIME_W'(limits.long_lim)) begin
			sel_type = PT_LONG;
		end else begin
			sel_type = PT_VERY_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			served_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				served_q   <= '0;
			end else begin
				if (done) begin
					s1_valid_q <= 1'b0;
				end
				if (load) begin
					served_q <= served_q | onehot;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1 <= time_ms;
		end
		if (load) begin
			idx_q     <= sel;
			pressed_q <= evts[sel].pressed;
			type_q    <= sel_type;
			etime_q   <= time_s1;
			last_q    <= (remaining == '0);
		end
	end

	assign evt.valid         = out_valid_q;
	assign evt.button_index  = idx_q;
	assign evt.pressed       = pressed_q;
	assign evt.press_type    = type_q;
	assign evt.event_time_ms = etime_q;
	assign evt.last_event    = last_q;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted tick did not reach the merge stage");

	a_served_subset: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> ((served_q & ~mask) == '0))
		else $error("served slot that had no event");

	a_not_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (s1_valid_q && (pend != '0)))
		else $error("beat not marked last but no event is pending");

endmodule

// ----- hw/rtl/button_debounce_press_classifier.sv -----
// Top level of the button debounce and press classifier: config registers, tick state, lanes.
//
//   channel  dir  beat                                           accepted when
//   tick     in   raw_levels                                     tick.valid && tick.ready
//   evt      out  button_index pressed press_type time last     evt.valid && evt.ready
//   cfg      in   index data                                     cfg.valid && cfg.ready
//
// One tick is accepted per cycle while in_ready; events go via the lane registers to the output register.
// A tick with no event never waits; a tick with events holds the merge stage until its last one is loaded.
// The merging stage, which puts out one event beat per cycle unless evt stalls, sets the event rate.
// Reset sets all but merge data registers at once; no clearing pass. cfg.ready is always high.
// While evt is stalled, ticks keep entering until one with events waits in the merge stage.
`timescale 1ns / 1ps

module button_debounce_press_classifier (
	input  logic      clk,
	input  logic      arst_n,
	bdpc_tick_if.sink tick,
	bdpc_evt_if.source evt,
	bdpc_cfg_if.sink  cfg
);
	import bdpc_pkg::*;

	logic [NUM_BUTTONS-1:0] enable_q;
	logic [DEB_W-1:0]       deb_ticks_q;
	limits_t                limits_q;
	logic [TIME_W-1:0]      time_q;
	logic [NUM_BUTTONS-1:0] prev_raw_q;

	logic                   accept;
	logic                   in_ready;
	lane_evt_t              lane_evts [NUM_BUTTONS];

	assign accept     = tick.valid && tick.ready;
	assign tick.ready = in_ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q           <= ENABLE_RST;
			deb_ticks_q        <= DEBOUNCE_RST;
			limits_q.short_lim <= SHORT_RST;
			limits_q.medium_lim <= MEDIUM_RST;
			limits_q.long_lim  <= LONG_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENABLE_MASK: begin
					enable_q <= cfg.data[NUM_BUTTONS-1:0];
				end
				REG_DEBOUNCE: begin
					deb_ticks_q <= cfg.data[DEB_W-1:0];
				end
				REG_SHORT_LIM: begin
					limits_q.short_lim <= cfg.data[LIM_W-1:0];
				end
				REG_MEDIUM_LIM: begin
					limits_q.medium_lim <= cfg.data[LIM_W-1:0];
				end
				REG_LONG_LIM: begin
					limits_q.long_lim <= cfg.data[LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			prev_raw_q <= '1;
		end else if (accept) begin
			time_q     <= time_q + TIME_W'(1);
			prev_raw_q <= tick.raw_levels;
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bdpc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.accept    (accept),
			.enable    (enable_q[g]),
			.level     (tick.raw_levels[g]),
			.prev      (prev_raw_q[g]),
			.deb_ticks (deb_ticks_q),
			.time_ms   (time_q),
			.evt_s1    (lane_evts[g])
		);
	end

	bdpc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.time_ms  (time_q),
		.evts     (lane_evts),
		.limits   (limits_q),
		.in_ready (in_ready),
		.evt      (evt)
	);

endmodule
